>>> hdl/cfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfr_pkg
// Sizes, register indexes and shared types of the continued fraction core.
// ----------------------------------------------------------------------------
package cfr_pkg;

    localparam int INT_BITS  = 16;
    localparam int FRAC_BITS = 32;
    localparam int MAX_TERMS = 64;

    localparam int IN_W    = INT_BITS + FRAC_BITS + 1;
    localparam int NUM_W   = INT_BITS + FRAC_BITS + 1;
    localparam int DEN_W   = FRAC_BITS + 1;
    localparam int WHOLE_W = INT_BITS;
    localparam int DIG_W   = 4;

    // remainder, divisor, power of ten (10^15 max) and product widths
    localparam int REM_W = FRAC_BITS;
    localparam int Q_W   = FRAC_BITS + 1;
    localparam int PW_W  = 50;
    localparam int DD_W  = 2 * FRAC_BITS;
    localparam int RHS_W = Q_W + DD_W;
    localparam int LHS_W = REM_W + PW_W;
    localparam int CMP_W = (LHS_W > RHS_W) ? LHS_W : RHS_W;
    localparam int MB_W  = (DD_W > PW_W) ? DD_W : PW_W;
    localparam int CNT_W = $clog2(Q_W);
    localparam int TRM_W = $clog2(MAX_TERMS + 1);

    localparam int OUT_W       = 1 + WHOLE_W + NUM_W + DEN_W;
    localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = DIG_W;

    localparam logic [CFG_IDX_W-1:0] CFG_PRECISION = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MODE      = CFG_IDX_W'(1);

    localparam logic [DIG_W-1:0] PRECISION_RESET = DIG_W'(6);

    typedef struct packed {
        logic                 negative;
        logic [WHOLE_W-1:0]   whole_part;
        logic [NUM_W-1:0]     numerator;
        logic [DEN_W-1:0]     denominator;
    } cfr_result_t;

endpackage

>>> hdl/cfr_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfr_engine
// Sequencer around one shift-add multiplier and one restoring divider that
// expands convergents until tolerance is met, remainder is 0 or a limit hits.
// ----------------------------------------------------------------------------
module cfr_engine (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [cfr_pkg::IN_W-1:0]      value,
    input  logic [cfr_pkg::DIG_W-1:0]     digits,
    input  logic                          improper,
    output logic                          idle,
    output logic                          res_valid,
    input  logic                          res_ready,
    output cfr_pkg::cfr_result_t          res
);
    import cfr_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE    = 10'b0000000001,
        ST_POW     = 10'b0000000010,
        ST_CHECK   = 10'b0000000100,
        ST_MUL_DD  = 10'b0000001000,
        ST_MUL_RHS = 10'b0000010000,
        ST_MUL_LHS = 10'b0000100000,
        ST_CMP     = 10'b0001000000,
        ST_DIV     = 10'b0010000000,
        ST_UPDATE  = 10'b0100000000,
        ST_DONE    = 10'b1000000000
    } state_t;

    state_t             state_reg, state_next;
    logic [Q_W-1:0]     q_reg, q_next;
    logic [REM_W-1:0]   r_reg, r_next;
    logic [NUM_W-1:0]   n_reg, n_next, n1_reg, n1_next;
    logic [DEN_W-1:0]   d_reg, d_next, d1_reg, d1_next;
    logic [PW_W-1:0]    pw_reg, pw_next;
    logic [DIG_W-1:0]   dig_reg, dig_next;
    logic               neg_reg, neg_next;
    logic [WHOLE_W-1:0] whole_reg, whole_next;
    logic [TRM_W-1:0]   terms_reg, terms_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CMP_W-1:0]   acc_reg, acc_next;
    logic [MB_W-1:0]    mb_reg, mb_next;
    logic [Q_W-1:0]     ma_reg, ma_next;
    logic [RHS_W-1:0]   rhs_reg, rhs_next;
    logic [Q_W-1:0]     rem_reg, rem_next;
    logic [NUM_W-1:0]   nacc_reg, nacc_next;
    logic [DEN_W-1:0]   dacc_reg, dacc_next;

    logic [IN_W-1:0]    mag;
    logic [IN_W-1:0]    mag_sat;
    logic [IN_W-1:0]    p_start;
    logic [CMP_W-1:0]   mul_sum;
    logic [Q_W-1:0]     div_shift;
    logic               div_ge;

    assign mag     = value[IN_W-1] ? (~value + IN_W'(1)) : value;
    assign mag_sat = mag[IN_W-1] ? {1'b0, {(IN_W-1){1'b1}}} : mag;
    assign p_start = improper ? mag : {{(INT_BITS+1){1'b0}}, mag_sat[FRAC_BITS-1:0]};

    assign mul_sum   = {acc_reg[CMP_W-2:0], 1'b0} + (ma_reg[Q_W-1] ? CMP_W'(mb_reg) : '0);
    assign div_shift = {rem_reg[Q_W-2:0], ma_reg[Q_W-1]};
    assign div_ge    = div_shift >= Q_W'(r_reg);

    always_comb begin
        state_next = state_reg;
        q_next     = q_reg;
        r_next     = r_reg;
        n_next     = n_reg;
        n1_next    = n1_reg;
        d_next     = d_reg;
        d1_next    = d1_reg;
        pw_next    = pw_reg;
        dig_next   = dig_reg;
        neg_next   = neg_reg;
        whole_next = whole_reg;
        terms_next = terms_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        mb_next    = mb_reg;
        ma_next    = ma_reg;
        rhs_next   = rhs_reg;
        rem_next   = rem_reg;
        nacc_next  = nacc_reg;
        dacc_next  = dacc_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    neg_next   = value[IN_W-1];
                    whole_next = improper ? '0 : mag_sat[IN_W-2:FRAC_BITS];
                    q_next     = Q_W'(1) << FRAC_BITS;
                    r_next     = p_start[FRAC_BITS-1:0];
                    n_next     = NUM_W'(p_start >> FRAC_BITS);
                    n1_next    = NUM_W'(1);
                    d_next     = DEN_W'(1);
                    d1_next    = '0;
                    pw_next    = PW_W'(1);
                    dig_next   = digits;
                    terms_next = '0;
                    state_next = ST_POW;
                end
            end
            ST_POW: begin
                if (dig_reg != '0) begin
                    pw_next  = (pw_reg << 3) + (pw_reg << 1);
                    dig_next = dig_reg - DIG_W'(1);
                end else begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (r_reg == '0 || d_reg[DEN_W-1] || terms_reg == TRM_W'(MAX_TERMS)) begin
                    state_next = ST_DONE;
                end else begin
                    ma_next    = Q_W'(d_reg);
                    mb_next    = MB_W'(d_reg);
                    acc_next   = '0;
                    cnt_next   = CNT_W'(Q_W - 1);
                    state_next = ST_MUL_DD;
                end
            end
            ST_MUL_DD: begin
                acc_next = mul_sum;
                ma_next  = ma_reg << 1;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0) begin
                    ma_next    = q_reg;
                    mb_next    = MB_W'(mul_sum[DD_W-1:0]);
                    acc_next   = '0;
                    cnt_next   = CNT_W'(Q_W - 1);
                    state_next = ST_MUL_RHS;
                end
            end
            ST_MUL_RHS: begin
                acc_next = mul_sum;
                ma_next  = ma_reg << 1;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0) begin
                    rhs_next   = mul_sum[RHS_W-1:0];
                    ma_next    = Q_W'(r_reg);
                    mb_next    = MB_W'(pw_reg);
                    acc_next   = '0;
                    cnt_next   = CNT_W'(Q_W - 1);
                    state_next = ST_MUL_LHS;
                end
            end
            ST_MUL_LHS: begin
                acc_next = mul_sum;
                ma_next  = ma_reg << 1;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0) begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                if (acc_reg <= CMP_W'(rhs_reg)) begin
                    state_next = ST_DONE;
                end else begin
                    ma_next    = q_reg;
                    rem_next   = '0;
                    nacc_next  = '0;
                    dacc_next  = '0;
                    cnt_next   = CNT_W'(Q_W - 1);
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                rem_next  = div_ge ? (div_shift - Q_W'(r_reg)) : div_shift;
                ma_next   = ma_reg << 1;
                nacc_next = (nacc_reg << 1) + (div_ge ? n_reg : '0);
                dacc_next = (dacc_reg << 1) + (div_ge ? d_reg : '0);
                cnt_next  = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                n_next     = n1_reg + nacc_reg;
                n1_next    = n_reg;
                d_next     = d1_reg + dacc_reg;
                d1_next    = d_reg;
                q_next     = Q_W'(r_reg);
                r_next     = rem_reg[REM_W-1:0];
                terms_next = terms_reg + TRM_W'(1);
                state_next = ST_CHECK;
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg     <= q_next;
        r_reg     <= r_next;
        n_reg     <= n_next;
        n1_reg    <= n1_next;
        d_reg     <= d_next;
        d1_reg    <= d1_next;
        pw_reg    <= pw_next;
        dig_reg   <= dig_next;
        neg_reg   <= neg_next;
        whole_reg <= whole_next;
        terms_reg <= terms_next;
        cnt_reg   <= cnt_next;
        acc_reg   <= acc_next;
        mb_reg    <= mb_next;
        ma_reg    <= ma_next;
        rhs_reg   <= rhs_next;
        rem_reg   <= rem_next;
        nacc_reg  <= nacc_next;
        dacc_reg  <= dacc_next;
    end

    assign idle      = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);

    assign res.negative    = neg_reg;
    assign res.whole_part  = whole_reg;
    assign res.numerator   = n_reg;
    assign res.denominator = d_reg;

    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |-> r_reg != '0)
        else $error("division started with zero remainder");

    a_rem_below: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |-> rem_reg < Q_W'(r_reg))
        else $error("partial remainder not below divisor");

    a_den_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DONE |-> d_reg != '0)
        else $error("zero denominator in result");

    a_terms_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_UPDATE |-> terms_reg < TRM_W'(MAX_TERMS))
        else $error("term count past limit");

endmodule

>>> hdl/continued_fraction_rationalizer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// continued_fraction_rationalizer_core
// Fixed-point to fraction converter by continued fraction convergents.
// ----------------------------------------------------------------------------
// One beat first builds the power of ten for precision_digits, then expands
// convergent terms (at most MAX_TERMS), then runs a last check and, unless
// that check already stops it, a last tolerance test, and then hands the
// result over; each term runs a check step, three shift-add products for the
// tolerance test, a compare step, one restoring division and an update step
// through the single engine. s_tready is low while a beat is in the engine; a
// finished result waits in the output register, so the next beat is taken as
// soon as the engine hands it over.
// Configuration writes are taken at any time and must arrive while idle.
module continued_fraction_rationalizer_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [cfr_pkg::IN_TDATA_W-1:0]      s_tdata,   // value
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [cfr_pkg::OUT_TDATA_W-1:0]     m_tdata,   // negative, whole_part,
                                                           // numerator, denominator
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [cfr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [cfr_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import cfr_pkg::*;

    logic [DIG_W-1:0]   digits_reg, digits_next;
    logic               mode_reg, mode_next;
    logic               out_valid_reg, out_valid_next;
    cfr_result_t        out_reg, out_next;

    logic               eng_idle;
    logic               eng_valid;
    logic               eng_ready;
    cfr_result_t        eng_res;

    assign cfg_ready = 1'b1;
    assign s_tready  = eng_idle;
    assign eng_ready = !out_valid_reg || m_tready;

    cfr_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (s_tvalid && s_tready),
        .value     (s_tdata[IN_W-1:0]),
        .digits    (digits_reg),
        .improper  (mode_reg),
        .idle      (eng_idle),
        .res_valid (eng_valid),
        .res_ready (eng_ready),
        .res       (eng_res)
    );

    always_comb begin
        digits_next = digits_reg;
        mode_next   = mode_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_PRECISION: digits_next = cfg_data[DIG_W-1:0];
                CFG_MODE:      mode_next   = cfg_data[0];
                default:       digits_next = digits_reg;
            endcase
        end
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (eng_valid && eng_ready) begin
            out_next       = eng_res;
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            digits_reg    <= PRECISION_RESET;
            mode_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            digits_reg    <= digits_next;
            mode_reg      <= mode_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W-OUT_W){1'b0}}, out_reg.denominator, out_reg.numerator,
                       out_reg.whole_part, out_reg.negative};

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the continued fraction core. Fixed-point values are
// streamed in, each result is compared field by field against an exact
// integer Euclid expansion done here, under several tolerance and mode
// settings and with random idle cycles on both stream sides.
// ----------------------------------------------------------------------------
module tb_top;
    import cfr_pkg::*;

    localparam int RAND_ITEMS = 350;

    typedef struct {
        logic               negative;
        logic [WHOLE_W-1:0] whole_part;
        logic [NUM_W-1:0]   numerator;
        logic [DEN_W-1:0]   denominator;
    } fraction_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    fraction_t   pending_fractions[$];
    int          mismatch_count = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int unsigned tol_digits = PRECISION_RESET;
    bit          keep_integer = 1'b0;

    continued_fraction_rationalizer_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #4 aclk = ~aclk;

    function automatic fraction_t best_fraction(logic [IN_W-1:0] raw);
        fraction_t       f;
        logic [IN_W-1:0] mag;
        longint unsigned q, p, r, a, n, n1, d, d1, pw, rem, t;
        logic [127:0]    lhs, rhs;
        int              terms;
        bit              done;
        pw = 1;
        for (int i = 0; i < tol_digits; i++) pw = pw * 10;
        f.negative = raw[IN_W-1];
        mag = raw[IN_W-1] ? -raw : raw;
        q = 64'd1 << FRAC_BITS;
        f.whole_part = '0;
        if (!keep_integer) begin
            if (mag > {1'b0, {(IN_W-1){1'b1}}}) mag = {1'b0, {(IN_W-1){1'b1}}};
            f.whole_part = mag[IN_W-2:FRAC_BITS];
            p = mag[FRAC_BITS-1:0];
        end else begin
            p = mag;
        end
        a = p / q;
        r = p % q;
        n = a; n1 = 1; d = 1; d1 = 0;
        terms = 0;
        forever begin
            if (r == 0 || d > 64'hFFFF_FFFF) begin
                done = 1'b1;
            end else begin
                lhs = 128'(r) * 128'(pw);
                rhs = 128'(q) * 128'(d * d);
                done = lhs <= rhs;
            end
            if (done || terms >= MAX_TERMS) break;
            a = q / r;
            rem = q % r;
            q = r;
            r = rem;
            t = n1 + a * n; n1 = n; n = t;
            t = d1 + a * d; d1 = d; d = t;
            terms++;
        end
        f.numerator = n[NUM_W-1:0];
        f.denominator = d[DEN_W-1:0];
        return f;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        fraction_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_fractions.size() == 0) begin
                $display("unexpected result beat at %0t", $realtime);
                mismatch_count++;
            end else begin
                want = pending_fractions.pop_front();
                if (m_tdata[0] !== want.negative)
                    report_mismatch("negative", m_tdata[0], want.negative);
                if (m_tdata[WHOLE_W:1] !== want.whole_part)
                    report_mismatch("whole_part", m_tdata[WHOLE_W:1], want.whole_part);
                if (m_tdata[WHOLE_W+NUM_W:WHOLE_W+1] !== want.numerator)
                    report_mismatch("numerator", m_tdata[WHOLE_W+NUM_W:WHOLE_W+1],
                                    want.numerator);
                if (m_tdata[OUT_W-1:WHOLE_W+NUM_W+1] !== want.denominator)
                    report_mismatch("denominator", m_tdata[OUT_W-1:WHOLE_W+NUM_W+1],
                                    want.denominator);
            end
        end
    end

    task automatic send_value(logic [IN_W-1:0] v);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = IN_TDATA_W'(v);
        do @(posedge aclk); while (!s_tready);
        pending_fractions.push_back(best_fraction(v));
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_fractions.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_PRECISION) tol_digits = data;
        else if (idx == CFG_MODE) keep_integer = data[0];
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_config(int unsigned digits, bit improper);
        wait_drained();
        write_reg(CFG_PRECISION, CFG_DATA_W'(digits));
        write_reg(CFG_MODE, CFG_DATA_W'(improper));
    endtask

    function automatic logic [IN_W-1:0] random_value();
        logic [63:0] v;
        int unsigned den;
        v = {$urandom, $urandom};
        case ($urandom_range(3))
            0: return v[IN_W-1:0];
            1: return IN_W'($signed(v[FRAC_BITS+2:0]));
            2: begin
                den = $urandom_range(1, 1000);
                v = (64'($urandom_range(0, 3 * den)) << FRAC_BITS) / den;
                return $urandom_range(1) ? -v[IN_W-1:0] : v[IN_W-1:0];
            end
            default: return {v[0], {(IN_W-1){v[1]}}} ^ IN_W'(v[3:2]);
        endcase
    endfunction

    task automatic test_directed();
        logic [IN_W-1:0] edge_vals[12];
        edge_vals = '{ '0, IN_W'(1), -IN_W'(1), {1'b0, {(IN_W-1){1'b1}}},
                       {1'b1, {(IN_W-1){1'b0}}}, {1'b1, {(IN_W-2){1'b0}}, 1'b1},
                       IN_W'(64'd3 << FRAC_BITS), -IN_W'(64'd7 << FRAC_BITS),
                       IN_W'(64'h0_8000_0000), IN_W'(64'h3_243F_6A88),
                       -IN_W'(64'h0_5555_5555), IN_W'(64'h0_FFFF_FFFF) };
        foreach (edge_vals[i]) send_value(edge_vals[i]);
        set_config(15, 1'b1);
        foreach (edge_vals[i]) send_value(edge_vals[i]);
        set_config(0, 1'b0);
        for (int i = 3; i < 7; i++) send_value(edge_vals[i]);
    endtask

    task automatic test_pause_until_drained();
        set_config(12, 1'b0);
        repeat (4) begin
            send_value(random_value());
            wait_drained();
        end
    endtask

    task automatic test_random();
        int unsigned digit_set[6] = '{0, 3, 6, 9, 12, 15};
        int          phase_items;
        phase_items = RAND_ITEMS / 18;
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 26 : (ph == 1) ? 88 : 0;
            recv_idle_pct = (ph == 0) ? 88 : (ph == 1) ? 26 : 0;
            foreach (digit_set[k]) begin
                set_config(digit_set[k], (k + ph) % 2);
                repeat (phase_items) send_value(random_value());
                if ($urandom_range(1)) send_value(random_value());
            end
        end
        send_idle_pct = 0;
        recv_idle_pct = 0;
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_directed();
        test_pause_until_drained();
        test_random();
        wait_drained();
        if (mismatch_count == 0 && pending_fractions.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #(64'd90_000_000);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> continued_fraction_rationalizer_core.f
hdl/cfr_pkg.sv
hdl/cfr_engine.sv
hdl/continued_fraction_rationalizer_core.sv
tb/tb_top.sv
